>>> hw/rtl/psgm_pkg.sv
package psgm_pkg;

   localparam int NUM_KEYS     = 256;
   localparam int GROUP_SIZE   = 4;
   localparam int GROUP_COUNT  = 64;
   localparam int MAX_KEY_DIMS = 128;
   localparam int MAX_WIDTH    = 64;

   localparam int KEY_IDX_W = $clog2(NUM_KEYS);
   localparam int DIM_IDX_W = $clog2(MAX_WIDTH);
   localparam int GROUP_W   = $clog2(GROUP_COUNT);
   localparam int MEMBER_W  = $clog2(GROUP_SIZE);
   localparam int KEY_AW    = KEY_IDX_W + DIM_IDX_W;
   localparam int PROJ_W    = 38;
   localparam int CNT_W     = 15;

   // register indexes on the csr port
   localparam logic [2:0] CSR_KEY_DIMS     = 3'd0;
   localparam logic [2:0] CSR_DIM_OFFSET   = 3'd1;
   localparam logic [2:0] CSR_DIM_WIDTH    = 3'd2;
   localparam logic [2:0] CSR_CLUSTER_BASE = 3'd3;
   localparam logic [2:0] CSR_KEY_BASE     = 3'd4;

   typedef struct packed {
      logic              is_read;
      logic signed [31:0] element_value;
      logic [5:0]        group_index;
   } item_type;

   typedef struct packed {
      logic [7:0]  key_dims;
      logic [6:0]  dim_offset;
      logic [6:0]  dim_width;
      logic [15:0] cluster_base;
      logic [23:0] key_base;
   } cfg_type;

   typedef struct packed {
      logic [15:0]        parent_id;
      logic [5:0]         dim_index;
      logic signed [31:0] mean_value;
      logic [24:0]        child_first;
      logic [24:0]        child_second;
      logic [24:0]        child_third;
      logic [24:0]        child_fourth;
      logic               last;
      logic               loaded;
   } rsp_type;

endpackage

>>> hw/rtl/psgm_ram.sv
module psgm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> hw/rtl/psgm_front.sv
module psgm_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               op,
   input  logic signed [31:0] element_value,
   input  logic [5:0]         group_index,
   output logic               busy,
   input  logic               pop,
   output logic               head_valid,
   output psgm_pkg::item_type head
);
   import psgm_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;

   assign busy       = (count_ff == 2'd2);
   assign push       = start && !busy;
   assign head_valid = (count_ff != 2'd0);
   assign head       = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff].is_read       <= op;
         slot_ff[wr_ptr_ff].element_value <= element_value;
         slot_ff[wr_ptr_ff].group_index   <= group_index;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

>>> hw/rtl/psgm_back.sv
module psgm_back (
   input  logic               clock,
   input  logic               reset,
   input  psgm_pkg::cfg_type  cfg,
   input  logic               kd_write,
   input  logic               head_valid,
   input  psgm_pkg::item_type head,
   output logic               pop,
   output logic               rsp_valid,
   output psgm_pkg::rsp_type  rsp
);
   import psgm_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DIV    = 4'd1;
   localparam logic [3:0] S_PROJ   = 4'd2;
   localparam logic [3:0] S_PI_REQ = 4'd3;
   localparam logic [3:0] S_PI_GET = 4'd4;
   localparam logic [3:0] S_CMP    = 4'd5;
   localparam logic [3:0] S_WR     = 4'd6;
   localparam logic [3:0] S_ORD    = 4'd7;
   localparam logic [3:0] S_SUM    = 4'd8;
   localparam logic [3:0] S_EMIT   = 4'd9;

   logic [3:0]            state_ff, state_in;
   logic                  dirty_ff, dirty_in;
   logic                  ready_ff, ready_in;
   logic [CNT_W-1:0]      counter_ff, counter_in;
   logic [CNT_W-1:0]      key_ff, key_in;
   logic [6:0]            dim_ff, dim_in;
   logic [7:0]            rem_ff, rem_in;
   logic [CNT_W-1:0]      quo_ff, quo_in;
   logic [3:0]            dcnt_ff, dcnt_in;
   logic [KEY_IDX_W:0]    pk_ff, pk_in;
   logic [DIM_IDX_W-1:0]  pd_ff, pd_in;
   logic                  pv_ff, pv_in, plast_ff, plast_in, pfirst_ff, pfirst_in;
   logic [KEY_IDX_W-1:0]  pkey_ff, pkey_in;
   logic signed [PROJ_W-1:0] acc_ff, acc_in, pi_ff, pi_in;
   logic [KEY_IDX_W-1:0]  si_ff, si_in, sjt_ff, sjt_in, rank_ff, rank_in;
   logic [KEY_IDX_W:0]    sj_ff, sj_in;
   logic                  sv_ff, sv_in;
   logic [GROUP_W-1:0]    g_ff, g_in;
   logic [MEMBER_W:0]     rc_ff, rc_in;
   logic                  rv_ff, rv_in;
   logic [MEMBER_W-1:0]   rtag_ff, rtag_in;
   logic [KEY_IDX_W-1:0]  child_ff [GROUP_SIZE];
   logic [KEY_IDX_W-1:0]  child_in [GROUP_SIZE];
   logic [DIM_IDX_W-1:0]  rd_ff, rd_in;
   logic signed [33:0]    msum_ff, msum_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // effective configuration
   logic [7:0] kd;
   logic [6:0] wsat, weff;
   logic [7:0] room;
   logic [15:0] total;

   // memory ports
   logic                 key_we;
   logic [KEY_AW-1:0]    key_waddr, key_raddr;
   logic [31:0]          key_rdata;
   logic                 proj_we;
   logic [KEY_IDX_W-1:0] proj_waddr, proj_raddr;
   logic [PROJ_W-1:0]    proj_wdata, proj_rdata;
   logic                 ord_we;
   logic [KEY_IDX_W-1:0] ord_waddr, ord_raddr;
   logic [KEY_IDX_W-1:0] ord_rdata;

   always_comb begin
      kd = cfg.key_dims;
      if (cfg.key_dims == 8'd0) begin
         kd = 8'd1;
      end else if (cfg.key_dims > 8'(MAX_KEY_DIMS)) begin
         kd = 8'(MAX_KEY_DIMS);
      end
      wsat = (cfg.dim_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : cfg.dim_width;
      // room reaches 128 for a full-length key, so it keeps eight bits
      room = kd - {1'b0, cfg.dim_offset};
      if ({1'b0, cfg.dim_offset} >= kd) begin
         weff = 7'd0;
      end else if ({1'b0, wsat} > room) begin
         weff = room[6:0];
      end else begin
         weff = wsat;
      end
      total = {kd, 8'd0};
   end

   psgm_ram #(.WIDTH(32), .DEPTH(NUM_KEYS * MAX_WIDTH)) u_key_ram (
      .clock(clock), .we(key_we), .waddr(key_waddr), .wdata(head.element_value),
      .raddr(key_raddr), .rdata(key_rdata));

   psgm_ram #(.WIDTH(PROJ_W), .DEPTH(NUM_KEYS)) u_proj_ram (
      .clock(clock), .we(proj_we), .waddr(proj_waddr), .wdata(proj_wdata),
      .raddr(proj_raddr), .rdata(proj_rdata));

   psgm_ram #(.WIDTH(KEY_IDX_W), .DEPTH(NUM_KEYS)) u_ord_ram (
      .clock(clock), .we(ord_we), .waddr(ord_waddr), .wdata(si_ff),
      .raddr(ord_raddr), .rdata(ord_rdata));

   always_comb begin
      logic [8:0]               t;
      logic                     qbit;
      logic [6:0]               rel;
      logic signed [PROJ_W-1:0] sum;
      logic signed [PROJ_W-1:0] pj;
      logic signed [33:0]       ms;
      logic [6:0]               n;

      state_in = state_ff;   dirty_in = dirty_ff || kd_write;
      ready_in = ready_ff;   counter_in = counter_ff; key_in = key_ff; dim_in = dim_ff;
      rem_in = rem_ff; quo_in = quo_ff; dcnt_in = dcnt_ff;
      pk_in = pk_ff; pd_in = pd_ff; pv_in = 1'b0; plast_in = plast_ff;
      pfirst_in = pfirst_ff; pkey_in = pkey_ff; acc_in = acc_ff; pi_in = pi_ff;
      si_in = si_ff; sj_in = sj_ff; sv_in = 1'b0; sjt_in = sjt_ff; rank_in = rank_ff;
      g_in = g_ff; rc_in = rc_ff; rv_in = 1'b0; rtag_in = rtag_ff; rd_in = rd_ff;
      msum_in = msum_ff; rsp_in = rsp_ff; rsp_valid_in = 1'b0;
      for (int i = 0; i < GROUP_SIZE; i++) begin
         child_in[i] = child_ff[i];
      end
      pop = 1'b0;
      key_we = 1'b0; key_waddr = '0; key_raddr = '0;
      proj_we = 1'b0; proj_waddr = pkey_ff; proj_wdata = '0; proj_raddr = si_ff;
      ord_we = 1'b0; ord_waddr = rank_ff; ord_raddr = '0;
      t = '0; qbit = 1'b0; rel = 7'(dim_ff - cfg.dim_offset);
      sum = '0; pj = '0; ms = '0;
      n = (weff == 7'd0) ? 7'd1 : weff;

      unique case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               if (head.is_read) begin
                  pop = 1'b1;
                  if (!ready_ff) begin
                     rsp_in = '0;
                     rsp_in.last = 1'b1;
                     rsp_valid_in = 1'b1;
                  end else begin
                     g_in = head.group_index;
                     rc_in = '0;
                     state_in = S_ORD;
                  end
               end else if (dirty_ff) begin
                  // key length changed: re-derive key and dimension from the count
                  rem_in = '0;
                  quo_in = counter_ff;
                  dcnt_in = '0;
                  state_in = S_DIV;
               end else begin
                  pop = 1'b1;
                  ready_in = 1'b0;
                  key_waddr = {key_ff[KEY_IDX_W-1:0], rel[DIM_IDX_W-1:0]};
                  key_we = (key_ff < CNT_W'(NUM_KEYS)) && (dim_ff >= cfg.dim_offset)
                           && (rel < wsat);
                  if ({1'b0, counter_ff} + 16'd1 >= total) begin
                     counter_in = '0; key_in = '0; dim_in = '0;
                     pk_in = '0; pd_in = '0;
                     state_in = S_PROJ;
                  end else begin
                     counter_in = counter_ff + 1'b1;
                     if ({1'b0, dim_ff} + 8'd1 == kd) begin
                        dim_in = '0;
                        key_in = key_ff + 1'b1;
                     end else begin
                        dim_in = dim_ff + 1'b1;
                     end
                  end
               end
            end
         end
         S_DIV: begin
            t = {rem_ff, quo_ff[CNT_W-1]};
            if (t >= {1'b0, kd}) begin
               t = t - {1'b0, kd};
               qbit = 1'b1;
            end
            rem_in = t[7:0];
            quo_in = {quo_ff[CNT_W-2:0], qbit};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == 4'(CNT_W - 1)) begin
               key_in = {quo_ff[CNT_W-2:0], qbit};
               dim_in = t[6:0];
               dirty_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_PROJ: begin
            if (!pk_ff[KEY_IDX_W]) begin
               if (weff == 7'd0) begin
                  proj_we = 1'b1;
                  proj_waddr = pk_ff[KEY_IDX_W-1:0];
                  pk_in = pk_ff + 1'b1;
               end else begin
                  key_raddr = {pk_ff[KEY_IDX_W-1:0], pd_ff};
                  pv_in = 1'b1;
                  plast_in = ({1'b0, pd_ff} == weff - 7'd1);
                  pfirst_in = (pd_ff == '0);
                  pkey_in = pk_ff[KEY_IDX_W-1:0];
                  if ({1'b0, pd_ff} == weff - 7'd1) begin
                     pd_in = '0;
                     pk_in = pk_ff + 1'b1;
                  end else begin
                     pd_in = pd_ff + 1'b1;
                  end
               end
            end
            if (pv_ff) begin
               sum = (pfirst_ff ? PROJ_W'(0) : acc_ff)
                     + PROJ_W'($signed(key_rdata));
               acc_in = sum;
               if (plast_ff) begin
                  proj_we = 1'b1;
                  proj_waddr = pkey_ff;
                  proj_wdata = sum;
               end
            end
            if (pk_ff[KEY_IDX_W] && !pv_ff) begin
               si_in = '0;
               state_in = S_PI_REQ;
            end
         end
         S_PI_REQ: begin
            proj_raddr = si_ff;
            state_in = S_PI_GET;
         end
         S_PI_GET: begin
            pi_in = proj_rdata;
            sj_in = '0;
            rank_in = '0;
            state_in = S_CMP;
         end
         S_CMP: begin
            // rank = keys with smaller projection, or equal and lower index
            if (!sj_ff[KEY_IDX_W]) begin
               proj_raddr = sj_ff[KEY_IDX_W-1:0];
               sv_in = 1'b1;
               sjt_in = sj_ff[KEY_IDX_W-1:0];
               sj_in = sj_ff + 1'b1;
            end
            if (sv_ff) begin
               pj = proj_rdata;
               if (pj < pi_ff || (pj == pi_ff && sjt_ff < si_ff)) begin
                  rank_in = rank_ff + 1'b1;
               end
            end
            if (sj_ff[KEY_IDX_W] && !sv_ff) begin
               state_in = S_WR;
            end
         end
         S_WR: begin
            ord_we = 1'b1;
            if (si_ff == KEY_IDX_W'(NUM_KEYS - 1)) begin
               ready_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               si_in = si_ff + 1'b1;
               state_in = S_PI_REQ;
            end
         end
         S_ORD: begin
            if (!rc_ff[MEMBER_W]) begin
               ord_raddr = {g_ff, rc_ff[MEMBER_W-1:0]};
               rv_in = 1'b1;
               rtag_in = rc_ff[MEMBER_W-1:0];
               rc_in = rc_ff + 1'b1;
            end
            if (rv_ff) begin
               child_in[rtag_ff] = ord_rdata;
            end
            if (rc_ff[MEMBER_W] && !rv_ff) begin
               rd_in = '0;
               rc_in = '0;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (weff == 7'd0) begin
               msum_in = '0;
               state_in = S_EMIT;
            end else begin
               if (!rc_ff[MEMBER_W]) begin
                  key_raddr = {child_ff[rc_ff[MEMBER_W-1:0]], rd_ff};
                  rv_in = 1'b1;
                  rtag_in = rc_ff[MEMBER_W-1:0];
                  rc_in = rc_ff + 1'b1;
               end
               if (rv_ff) begin
                  ms = (rtag_ff == '0) ? 34'sd0 : msum_ff;
                  msum_in = ms + 34'($signed(key_rdata));
               end
               if (rc_ff[MEMBER_W] && !rv_ff) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            ms = msum_ff >>> MEMBER_W;
            rsp_in.parent_id = cfg.cluster_base + 16'(g_ff);
            rsp_in.dim_index = rd_ff;
            rsp_in.mean_value = ms[31:0];
            rsp_in.child_first = {1'b0, cfg.key_base} + 25'(child_ff[0]);
            rsp_in.child_second = {1'b0, cfg.key_base} + 25'(child_ff[1]);
            rsp_in.child_third = {1'b0, cfg.key_base} + 25'(child_ff[2]);
            rsp_in.child_fourth = {1'b0, cfg.key_base} + 25'(child_ff[3]);
            rsp_in.last = ({1'b0, rd_ff} + 7'd1 == n);
            rsp_in.loaded = 1'b1;
            rsp_valid_in = 1'b1;
            if ({1'b0, rd_ff} + 7'd1 == n) begin
               state_in = S_IDLE;
            end else begin
               rd_in = rd_ff + 1'b1;
               rc_in = '0;
               state_in = S_SUM;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dirty_ff <= 1'b0;
         ready_ff <= 1'b0;
         counter_ff <= '0;
         key_ff <= '0;
         dim_ff <= '0;
         pv_ff <= 1'b0;
         sv_ff <= 1'b0;
         rv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
         ready_ff <= ready_in;
         counter_ff <= counter_in;
         key_ff <= key_in;
         dim_ff <= dim_in;
         pv_ff <= pv_in;
         sv_ff <= sv_in;
         rv_ff <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; dcnt_ff <= dcnt_in;
      pk_ff <= pk_in; pd_ff <= pd_in; plast_ff <= plast_in; pfirst_ff <= pfirst_in;
      pkey_ff <= pkey_in; acc_ff <= acc_in; pi_ff <= pi_in;
      si_ff <= si_in; sj_ff <= sj_in; sjt_ff <= sjt_in; rank_ff <= rank_in;
      g_ff <= g_in; rc_ff <= rc_in; rtag_ff <= rtag_in; rd_ff <= rd_in;
      msum_ff <= msum_in; rsp_ff <= rsp_in;
      for (int i = 0; i < GROUP_SIZE; i++) begin
         child_ff[i] <= child_in[i];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

`ifndef SYNTHESIS
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == S_IDLE) && head_valid)
      else $error("pop outside idle");
   a_unloaded_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.loaded |-> rsp_ff.last)
      else $error("unloaded response not last");
   a_sort_clears_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROJ || state_ff == S_CMP) |-> !ready_ff)
      else $error("ready during sort");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (state_ff == S_IDLE) && !rsp_valid_ff)
      else $error("not idle after reset");
`endif
endmodule

>>> hw/rtl/projection_sort_group_means_core.sv
// projection sort and group means, one subspace of one head per buffer
// command channel: a transaction is taken when start is high and busy is low.
//   req_op 0 loads one key element, req_op 1 reads one group of four keys.
// result channel: rsp_valid marks each result for exactly one cycle, no stall.
// csr port: csr_write_enable with csr_index / csr_write_data, written while idle.
// loads run at one element per cycle, while the back end is idle, through
// a two-entry command queue; the back end's single key-store port sets that
// figure. after the last element of a buffer the back end sums projections
// (one key element per cycle) and ranks the 256 keys; busy rises once the
// queue fills.
// a read fetches the group's four key indexes, then sums one mean per dimension.
// writing key_dims adds a re-division before the next load.
// reset clears the counters and the loaded flag; the memories keep stale data.
module projection_sort_group_means_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_op,
   input  logic signed [31:0] req_element_value,
   input  logic [5:0]         req_group_index,
   output logic               rsp_valid,
   output logic [15:0]        rsp_parent_id,
   output logic [5:0]         rsp_dim_index,
   output logic signed [31:0] rsp_mean_value,
   output logic [24:0]        rsp_child_first,
   output logic [24:0]        rsp_child_second,
   output logic [24:0]        rsp_child_third,
   output logic [24:0]        rsp_child_fourth,
   output logic               rsp_last,
   output logic               rsp_loaded,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_write_data
);
   import psgm_pkg::*;

   cfg_type  cfg_ff;
   item_type head;
   rsp_type  rsp;
   logic     head_valid, pop, kd_write;

   // configuration registers
   assign kd_write = csr_write_enable && (csr_index == CSR_KEY_DIMS);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_dims     <= 8'(MAX_KEY_DIMS);
         cfg_ff.dim_offset   <= '0;
         cfg_ff.dim_width    <= 7'(MAX_WIDTH);
         cfg_ff.cluster_base <= '0;
         cfg_ff.key_base     <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KEY_DIMS:     cfg_ff.key_dims     <= csr_write_data[7:0];
            CSR_DIM_OFFSET:   cfg_ff.dim_offset   <= csr_write_data[6:0];
            CSR_DIM_WIDTH:    cfg_ff.dim_width    <= csr_write_data[6:0];
            CSR_CLUSTER_BASE: cfg_ff.cluster_base <= csr_write_data[15:0];
            CSR_KEY_BASE:     cfg_ff.key_base     <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // front: takes and classifies transactions into the queue
   psgm_front u_front (
      .clock(clock), .reset(reset), .start(start), .op(req_op),
      .element_value(req_element_value), .group_index(req_group_index),
      .busy(busy), .pop(pop), .head_valid(head_valid), .head(head));

   // back: load, projection, ranking and group readout
   psgm_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .kd_write(kd_write),
      .head_valid(head_valid), .head(head), .pop(pop),
      .rsp_valid(rsp_valid), .rsp(rsp));

   assign rsp_parent_id    = rsp.parent_id;
   assign rsp_dim_index    = rsp.dim_index;
   assign rsp_mean_value   = rsp.mean_value;
   assign rsp_child_first  = rsp.child_first;
   assign rsp_child_second = rsp.child_second;
   assign rsp_child_third  = rsp.child_third;
   assign rsp_child_fourth = rsp.child_fourth;
   assign rsp_last         = rsp.last;
   assign rsp_loaded       = rsp.loaded;
endmodule
